@@ rtl/ecdt_pkg.sv @@
`default_nettype none

package ecdt_pkg;

   localparam int unsigned PC_W    = 4;
   localparam int unsigned ACC_W   = 32;
   localparam int unsigned DVS_W   = 17;
   localparam int unsigned QUO_W   = 16;
   localparam int unsigned DAY_W   = 16;
   localparam int unsigned YEAR_W  = 12;
   localparam int unsigned MONTH_W = 4;

   localparam logic [YEAR_W-1:0]  FIRST_YEAR  = 12'd1970;
   localparam logic [YEAR_W-1:0]  SKIP_LEAP   = 12'd2100;
   localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;
   localparam logic [DAY_W-1:0]   EPOCH_WDAY  = 16'd4;

   // reciprocals, exact for the dividend ranges reached:
   // secs>>7 / 675, tod>>4 / 225, min_sec>>2 / 15, (days + 4) / 7
   localparam logic [25:0] RCP_DAY  = 26'd50903317;
   localparam logic [13:0] RCP_HOUR = 14'd9321;
   localparam logic [10:0] RCP_MIN  = 11'd1093;
   localparam logic [16:0] RCP_WEEK = 17'd74899;

   typedef enum logic [2:0] {
      OP_ACCEPT,
      OP_LOAD,
      OP_DIV,
      OP_YEAR,
      OP_MONTH,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      SV_NONE,
      SV_DAY,
      SV_HOUR,
      SV_MINSEC,
      SV_WDAY
   } save_type;

   typedef enum logic [1:0] {
      SRC_EPOCH,
      SRC_REM,
      SRC_DAY4
   } src_type;

   typedef enum logic [1:0] {
      DV_DAY,
      DV_HOUR,
      DV_MIN,
      DV_WEEK
   } dvs_type;

   typedef struct packed {
      op_type           op;
      save_type         save;
      src_type          src;
      dvs_type          dvs;
      logic [PC_W-1:0]  nxt;
   } ctrl_word_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [2:0]         weekday;
   } rsp_word_type;

   // control store: loops stay on their step until done, then jump to nxt;
   // a load takes the remainder of the division just before it
   function automatic ctrl_word_type rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '{op: OP_ACCEPT, save: SV_NONE, src: SRC_EPOCH, dvs: DV_DAY, nxt: 4'd1};
      unique case (pc)
         4'd0:  w = '{OP_ACCEPT, SV_NONE,   SRC_EPOCH, DV_DAY,  4'd1};
         4'd1:  w = '{OP_DIV,    SV_NONE,   SRC_REM,   DV_DAY,  4'd2};
         4'd2:  w = '{OP_LOAD,   SV_DAY,    SRC_REM,   DV_DAY,  4'd3};
         4'd3:  w = '{OP_DIV,    SV_NONE,   SRC_REM,   DV_HOUR, 4'd4};
         4'd4:  w = '{OP_LOAD,   SV_HOUR,   SRC_REM,   DV_HOUR, 4'd5};
         4'd5:  w = '{OP_DIV,    SV_NONE,   SRC_REM,   DV_MIN,  4'd6};
         4'd6:  w = '{OP_LOAD,   SV_MINSEC, SRC_DAY4,  DV_MIN,  4'd7};
         4'd7:  w = '{OP_DIV,    SV_NONE,   SRC_REM,   DV_WEEK, 4'd8};
         4'd8:  w = '{OP_LOAD,   SV_WDAY,   SRC_REM,   DV_WEEK, 4'd9};
         4'd9:  w = '{OP_YEAR,   SV_NONE,   SRC_REM,   DV_DAY,  4'd10};
         4'd10: w = '{OP_MONTH,  SV_NONE,   SRC_REM,   DV_DAY,  4'd11};
         4'd11: w = '{OP_EMIT,   SV_NONE,   SRC_REM,   DV_DAY,  4'd0};
         default: ;
      endcase
      return w;
   endfunction

   function automatic logic [DVS_W-1:0] divisor(input dvs_type d);
      logic [DVS_W-1:0] v;
      v = 17'd86400;
      unique case (d)
         DV_DAY:  v = 17'd86400;
         DV_HOUR: v = 17'd3600;
         DV_MIN:  v = 17'd60;
         DV_WEEK: v = 17'd7;
         default: v = 17'd86400;
      endcase
      return v;
   endfunction

   // quotient by reciprocal multiply; low divisor powers of two shifted out first
   function automatic logic [QUO_W-1:0] recip_quo(input dvs_type d,
                                                  input logic [ACC_W-1:0] x);
      logic [50:0]      p_day;
      logic [26:0]      p_hour;
      logic [20:0]      p_min;
      logic [32:0]      p_week;
      logic [QUO_W-1:0] q;
      p_day  = 51'(x[31:7]) * 51'(RCP_DAY);
      p_hour = 27'(x[16:4]) * 27'(RCP_HOUR);
      p_min  = 21'(x[11:2]) * 21'(RCP_MIN);
      p_week = 33'(x[15:0]) * 33'(RCP_WEEK);
      q = p_day[50:35];
      unique case (d)
         DV_DAY:  q = p_day[50:35];
         DV_HOUR: q = 16'(p_hour[26:21]);
         DV_MIN:  q = 16'(p_min[20:14]);
         DV_WEEK: q = 16'(p_week[32:19]);
         default: q = p_day[50:35];
      endcase
      return q;
   endfunction

   // years reached lie in 1970..2106; 2000 is the only century year
   // that is leap, 2100 the only one that is not
   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      return (y[1:0] == 2'b00) && (y != SKIP_LEAP);
   endfunction

   function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m,
                                             input logic leap);
      logic [4:0] len;
      len = 5'd31;
      unique case (m) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ rtl/epoch_to_calendar_datetime_unit.sv @@
`default_nettype none

// channel  dir  ports                                    word
// req      in   req_valid/req_ready, req_epoch_seconds   seconds since 1970-01-01
// rsp      out  rsp_valid/rsp_ready, rsp_year..weekday   calendar date and time
//
// From accept to rsp_valid: four divisions by constants done as
// reciprocal multiplies (quotient in one step, remainder with the following load),
// then one step per year after 1970 and one per month, each loop one more step
// to exit, and the emit step, all run by a 12-step control store.
// Synchronous reset returns the sequencer to its accept step and empties rsp.
// rsp is registered; the emit step stalls only while a word waits, and req is ready only at the accept step.
module epoch_to_calendar_datetime_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_epoch_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_year,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day,
   output logic [4:0]       rsp_hour,
   output logic [5:0]       rsp_minute,
   output logic [5:0]       rsp_second,
   output logic [2:0]       rsp_weekday
);

   logic [ecdt_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [ecdt_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [ecdt_pkg::QUO_W-1:0]   quo_ff, quo_in;
   logic [ecdt_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [ecdt_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [ecdt_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [4:0]                   hour_ff, hour_in;
   logic [5:0]                   minute_ff, minute_in;
   logic [5:0]                   second_ff, second_in;
   logic [2:0]                   wday_ff, wday_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ecdt_pkg::rsp_word_type       rsp_ff, rsp_in;

   ecdt_pkg::ctrl_word_type      word;
   logic [ecdt_pkg::DVS_W-1:0]   dv;
   logic [ecdt_pkg::QUO_W-1:0]   quo_calc;
   logic [ecdt_pkg::ACC_W-1:0]   rmd;
   logic                         leap;
   logic [8:0]                   ylen;
   logic [4:0]                   mlen;

   assign word = ecdt_pkg::rom(pc_ff);

   // datapath helpers
   always_comb begin
      dv       = ecdt_pkg::divisor(word.dvs);
      quo_calc = ecdt_pkg::recip_quo(word.dvs, acc_ff);
      rmd      = acc_ff - ecdt_pkg::ACC_W'(quo_ff) * ecdt_pkg::ACC_W'(dv);
      leap     = ecdt_pkg::is_leap(year_ff);
      ylen     = leap ? 9'd366 : 9'd365;
      mlen     = ecdt_pkg::month_days(month_ff, leap);
   end

   always_comb begin
      pc_in        = pc_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      day_in       = day_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      wday_in      = wday_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (word.op)
         ecdt_pkg::OP_ACCEPT, ecdt_pkg::OP_LOAD: begin
            if (word.op == ecdt_pkg::OP_LOAD || req_valid) begin
               // bank the finished division, then stage the next dividend
               unique case (word.save)
                  ecdt_pkg::SV_DAY:    day_in = quo_ff;
                  ecdt_pkg::SV_HOUR:   hour_in = quo_ff[4:0];
                  ecdt_pkg::SV_MINSEC: begin
                     minute_in = quo_ff[5:0];
                     second_in = rmd[5:0];
                  end
                  ecdt_pkg::SV_WDAY: begin
                     wday_in  = rmd[2:0];
                     year_in  = ecdt_pkg::FIRST_YEAR;
                     month_in = 4'd1;
                  end
                  default: ;
               endcase
               unique case (word.src)
                  ecdt_pkg::SRC_EPOCH: acc_in = req_epoch_seconds;
                  ecdt_pkg::SRC_DAY4:  acc_in = 32'(day_ff + ecdt_pkg::EPOCH_WDAY);
                  default:             acc_in = rmd;
               endcase
               pc_in = word.nxt;
            end
         end
         ecdt_pkg::OP_DIV: begin
            quo_in = quo_calc;
            pc_in  = word.nxt;
         end
         ecdt_pkg::OP_YEAR: begin
            if (day_ff < 16'(ylen)) begin
               pc_in = word.nxt;
            end else begin
               day_in  = day_ff - 16'(ylen);
               year_in = year_ff + 12'd1;
            end
         end
         ecdt_pkg::OP_MONTH: begin
            if (day_ff < 16'(mlen) || month_ff == ecdt_pkg::LAST_MONTH) begin
               pc_in = word.nxt;
            end else begin
               day_in   = day_ff - 16'(mlen);
               month_in = month_ff + 4'd1;
            end
         end
         ecdt_pkg::OP_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.year    = year_ff;
               rsp_in.month   = month_ff;
               rsp_in.day     = 5'(day_ff + 16'd1);
               rsp_in.hour    = hour_ff;
               rsp_in.minute  = minute_ff;
               rsp_in.second  = second_ff;
               rsp_in.weekday = wday_ff;
               rsp_valid_in   = 1'b1;
               pc_in          = word.nxt;
            end
         end
         default: pc_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      day_ff    <= day_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      wday_ff   <= wday_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready   = (word.op == ecdt_pkg::OP_ACCEPT);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_year    = rsp_ff.year;
   assign rsp_month   = rsp_ff.month;
   assign rsp_day     = rsp_ff.day;
   assign rsp_hour    = rsp_ff.hour;
   assign rsp_minute  = rsp_ff.minute;
   assign rsp_second  = rsp_ff.second;
   assign rsp_weekday = rsp_ff.weekday;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SECS_PER_DAY   = 86400;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          DRAIN_CYCLES   = 300;
   localparam int          HOLD_OFF_LEN   = 800;
   localparam int          PRINT_LIMIT    = 50;

   typedef struct {
      logic [31:0]                  secs;
      logic [ecdt_pkg::YEAR_W-1:0]  year;
      logic [ecdt_pkg::MONTH_W-1:0] month;
      logic [4:0]                   day;
      logic [4:0]                   hour;
      logic [5:0]                   minute;
      logic [5:0]                   second;
      logic [2:0]                   weekday;
   } calendar_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_epoch_seconds = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;

   calendar_word_type pending_dates[$];
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_off_left = 0;
   int mismatches    = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int quiet_cycles  = 0;

   epoch_to_calendar_datetime_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

   always #6 clock = ~clock;

   // full Gregorian rule, independent of the block's 2100 shortcut
   function automatic bit leap_year(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
   endfunction

   function automatic int unsigned year_days(input int unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   function automatic int unsigned month_len(input int unsigned y, input int unsigned m);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return leap_year(y) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   function automatic calendar_word_type to_calendar(input logic [31:0] secs);
      calendar_word_type r;
      int unsigned       days;
      int unsigned       tod;
      int unsigned       left;
      int unsigned       yr;
      int unsigned       mon;
      days = secs / SECS_PER_DAY;
      tod  = secs % SECS_PER_DAY;
      r.secs    = secs;
      r.hour    = 5'(tod / 3600);
      r.minute  = 6'((tod % 3600) / 60);
      r.second  = 6'(tod % 60);
      r.weekday = 3'((days + 4) % 7);   // 1970-01-01 was a Thursday
      left = days;
      yr   = 1970;
      while (left >= year_days(yr)) begin
         left -= year_days(yr);
         yr++;
      end
      mon = 1;
      while (mon < 12 && left >= month_len(yr, mon)) begin
         left -= month_len(yr, mon);
         mon++;
      end
      r.year  = 12'(yr);
      r.month = 4'(mon);
      r.day   = 5'(left + 1);
      return r;
   endfunction

   function automatic longint epoch_of(input int unsigned y, input int unsigned m,
                                       input int unsigned d);
      longint days;
      days = d - 1;
      for (int unsigned yy = 1970; yy < y; yy++) days += year_days(yy);
      for (int unsigned mm = 1; mm < m; mm++) days += month_len(y, mm);
      return days * SECS_PER_DAY;
   endfunction

   // half uniform, the rest clustered on day, month and year edges
   function automatic logic [31:0] random_epoch();
      longint e;
      case ($urandom_range(0, 3))
         2: begin
            e = longint'($urandom_range(0, 49710)) * SECS_PER_DAY;
            e += $urandom_range(0, 1) ? 86400 - $urandom_range(1, 3) : $urandom_range(0, 2);
         end
         3: begin
            e = epoch_of($urandom_range(1970, 2106), $urandom_range(1, 12), 1);
            e += longint'($urandom_range(0, 345600)) - 172800;
         end
         default: e = $urandom;
      endcase
      if (e < 0 || e > 32'hFFFF_FFFF) e = $urandom;
      return e[31:0];
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string field, input logic [31:0] got,
                                input logic [31:0] want, input logic [31:0] secs);
      if (got !== want)
         report_mismatch($sformatf("epoch %0d: %s is %0d, should be %0d",
                                   secs, field, got, want));
   endtask

   task automatic send_epoch(input logic [31:0] secs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_dates.push_back(to_calendar(secs));
      words_sent++;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_epoch(random_epoch());
   endtask

   // result side: check each accepted word, then pick next ready
   always @(posedge clock) begin
      calendar_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_dates.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d-%0d-%0d %0d:%0d:%0d",
                                         rsp_year, rsp_month, rsp_day,
                                         rsp_hour, rsp_minute, rsp_second));
            end else begin
               want = pending_dates.pop_front();
               compare_field("year",    32'(rsp_year),    32'(want.year),    want.secs);
               compare_field("month",   32'(rsp_month),   32'(want.month),   want.secs);
               compare_field("day",     32'(rsp_day),     32'(want.day),     want.secs);
               compare_field("hour",    32'(rsp_hour),    32'(want.hour),    want.secs);
               compare_field("minute",  32'(rsp_minute),  32'(want.minute),  want.secs);
               compare_field("second",  32'(rsp_second),  32'(want.second),  want.secs);
               compare_field("weekday", 32'(rsp_weekday), 32'(want.weekday), want.secs);
               words_checked++;
            end
         end
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles, %0d words outstanding",
                  quiet_cycles, pending_dates.size());
         $display("epoch_to_calendar_datetime_unit: mismatch");
         $finish;
      end
   end

   task automatic test_directed_dates();
      longint dates[$];
      dates = '{0, 1, 59, 60, 3599, 3600, 86399, 86400,
                epoch_of(1970, 12, 31) + 43200,
                epoch_of(1972, 2, 29), epoch_of(1972, 3, 1) - 1, epoch_of(1973, 1, 1) - 1,
                epoch_of(2000, 2, 29), epoch_of(2000, 3, 1), epoch_of(2001, 1, 1) - 1,
                epoch_of(2100, 3, 1) - 1, epoch_of(2100, 3, 1),
                32'h7FFF_FFFF, 32'h8000_0000, epoch_of(2106, 1, 1) - 1,
                epoch_of(2106, 1, 1), 32'h5555_5555, 32'hAAAA_AAAA,
                32'hFFFF_FFFE, 32'hFFFF_FFFF};
      foreach (dates[i]) send_epoch(dates[i][31:0]);
   endtask

   task automatic test_no_idle();
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(350);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 67;
      stall_pct     = 0;
      run_random(350);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      stall_pct     = 67;
      run_random(350);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 30;
      stall_pct     = 30;
      run_random(350);
   endtask

   // result held back long enough that the block backs up into req
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_off_left = HOLD_OFF_LEN;
      run_random(20);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_dates();
      test_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_output_hold_off();
      req_valid     <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d epochs converted, %0d words checked, %0d errors", words_sent,
               words_checked, mismatches);
      $display("covered: leap days, century years, 2038 and 2106 edges, idle mixes, hold-off");
      if (mismatches == 0)
         $display("epoch_to_calendar_datetime_unit: match");
      else
         $display("epoch_to_calendar_datetime_unit: mismatch");
      $finish;
   end

endmodule
